// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of this block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block clock and reset
`define ASSERT_BLK(label, prop, msg) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ----- hdl/pmw_pkg.sv -----
// Package of the minimum spanning tree weight block: widths, codes and control types
package pmw_pkg;

  // Built vertex limit and derived sizes
  localparam int unsigned MAX_V     = 128;
  localparam int unsigned VIDX_W    = $clog2(MAX_V);
  localparam int unsigned VCNT_W    = $clog2(MAX_V + 1);
  localparam int unsigned ADJ_DEPTH = MAX_V * MAX_V;
  localparam int unsigned ADDR_W    = $clog2(ADJ_DEPTH);

  // Field widths
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned ROW_W    = 7;
  localparam int unsigned COL_W    = 7;
  localparam int unsigned WEIGHT_W = 22;
  localparam int unsigned TW_W     = 28;
  localparam int unsigned VCOUNT_W = 8;

  // Configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // Value constants
  localparam logic [WEIGHT_W-1:0] NO_EDGE  = WEIGHT_W'(1 << 21);
  localparam logic [TW_W-1:0]     SUM_MAX  = '1;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(1);

  // Item actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE   = 2'd0,
    ACT_CLEAR   = 2'd1,
    ACT_COMPUTE = 2'd2
  } action_e;

  // Datapath sweep operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_INIT,
    OP_SCAN,
    OP_RELAX,
    OP_SUM
  } op_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_INIT,
    ST_SCAN,
    ST_SCAN_END,
    ST_PICK,
    ST_RELAX,
    ST_RELAX_END,
    ST_SUM,
    ST_SUM_D1,
    ST_SUM_D2,
    ST_DONE
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    op_e  op;       // operation issued at the current sweep index
    logic cnt_clr;  // restart the sweep counter
    logic load_n;   // latch the vertex count for a compute
    logic trk_clr;  // restart the minimum tracker
    logic acc_clr;  // clear the tree weight accumulator
    logic adj_wr;   // store the entry of the accepted write item
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;  // counter on the last matrix entry
    logic sweep_last;  // counter on the last vertex in use
    logic cfg_zero;    // configured vertex count is zero
    logic found;       // scan found an unfinished vertex below no-edge
  } dp_sts_t;

endpackage

// ----- hdl/pmw_ctrl.sv -----
// Controller state machine of the minimum spanning tree weight block
module pmw_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [pmw_pkg::ACTION_W-1:0]    action_i,
  input  pmw_pkg::dp_sts_t                sts_i,
  output pmw_pkg::dp_cmd_t                cmd_o,
  output logic                            busy_o,
  output logic                            done_o
);
  import pmw_pkg::*;

  state_e state_q, state_d;

  // State register; reset enters the matrix clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '{op: OP_NONE, default: 1'b0};
    busy_o  = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          unique case (action_i)
            ACT_WRITE: begin
              cmd_o.adj_wr = 1'b1;
            end
            ACT_CLEAR: begin
              cmd_o.cnt_clr = 1'b1;
              state_d       = ST_CLEAR;
            end
            ACT_COMPUTE: begin
              cmd_o.cnt_clr = 1'b1;
              cmd_o.load_n  = 1'b1;
              cmd_o.acc_clr = 1'b1;
              state_d       = sts_i.cfg_zero ? ST_DONE : ST_INIT;
            end
            default: begin
              // unused action: taken and dropped
            end
          endcase
        end
      end
      ST_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_INIT: begin
        cmd_o.op = OP_INIT;
        if (sts_i.sweep_last) begin
          cmd_o.cnt_clr = 1'b1;
          cmd_o.trk_clr = 1'b1;
          state_d       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.op = OP_SCAN;
        if (sts_i.sweep_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_SCAN_END;
        end
      end
      // last key compared here
      ST_SCAN_END: begin
        state_d = ST_PICK;
      end
      ST_PICK: begin
        state_d = sts_i.found ? ST_RELAX : ST_SUM;
      end
      ST_RELAX: begin
        cmd_o.op = OP_RELAX;
        if (sts_i.sweep_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_RELAX_END;
        end
      end
      // last neighbour written back here
      ST_RELAX_END: begin
        cmd_o.trk_clr = 1'b1;
        state_d       = ST_SCAN;
      end
      ST_SUM: begin
        cmd_o.op = OP_SUM;
        if (sts_i.sweep_last) begin
          state_d = ST_SUM_D1;
        end
      end
      ST_SUM_D1: begin
        state_d = ST_SUM_D2;
      end
      ST_SUM_D2: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/pmw_datapath.sv -----
// Datapath: adjacency memory, per-vertex working memory, tracker and accumulator
module pmw_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pmw_pkg::dp_cmd_t                 cmd_i,
  output pmw_pkg::dp_sts_t                 sts_o,
  input  logic [pmw_pkg::VCOUNT_W-1:0]     vertex_count_i,
  input  logic [pmw_pkg::ROW_W-1:0]        row_i,
  input  logic [pmw_pkg::COL_W-1:0]        col_i,
  input  logic [pmw_pkg::WEIGHT_W-1:0]     weight_i,
  output logic [pmw_pkg::TW_W-1:0]         tree_weight_o
);
  import pmw_pkg::*;

  // One working entry per vertex
  typedef struct packed {
    logic                has_parent;
    logic                fin;
    logic [VIDX_W-1:0]   parent;
    logic [WEIGHT_W-1:0] key;
  } work_t;

  function automatic logic [ADDR_W-1:0] adj_addr(logic [VIDX_W-1:0] r,
                                                 logic [VIDX_W-1:0] c);
    adj_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_V) + ADDR_W'(c));
  endfunction

  // Memories
  logic [WEIGHT_W-1:0] adj_mem [ADJ_DEPTH];
  work_t               work_mem [MAX_V];

  logic [ADDR_W-1:0]   cnt_q, cnt_d;
  logic [VCNT_W-1:0]   n_q, n_sat;
  op_e                 s1_op_q;
  logic [VIDX_W-1:0]   s1_idx_q;
  logic                s2_vld_q, s2_vld_d;
  logic [VIDX_W-1:0]   u_q;
  logic [WEIGHT_W-1:0] min_q;
  logic                found_q;
  logic [TW_W-1:0]     acc_q, acc_d;
  logic [TW_W:0]       acc_sum;

  logic [WEIGHT_W-1:0] adj_rd_q;
  work_t               work_rd_q;

  logic [VIDX_W-1:0]   cidx;
  logic [31:0]         vc_ext, row_ext, col_ext;
  logic                in_range;

  logic                adj_we;
  logic [ADDR_W-1:0]   adj_waddr, adj_raddr;
  logic [WEIGHT_W-1:0] adj_wdata;
  logic                work_we;
  logic [VIDX_W-1:0]   work_waddr;
  work_t               work_wdata;
  logic                scan_better;

  assign cidx = cnt_q[VIDX_W-1:0];

  // Vertex count in use, saturated to the built limit
  assign vc_ext = 32'(vertex_count_i);
  assign n_sat  = (vc_ext > MAX_V) ? VCNT_W'(MAX_V) : VCNT_W'(vc_ext);

  // Range check of a written entry
  assign row_ext  = 32'(row_i);
  assign col_ext  = 32'(col_i);
  assign in_range = (row_ext < MAX_V) && (col_ext < MAX_V);

  // Sweep counter
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.op != OP_NONE) begin
      cnt_d = cnt_q + ADDR_W'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      n_q      <= '0;
      s1_op_q  <= OP_NONE;
      s2_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      s1_op_q  <= cmd_i.op;
      s2_vld_q <= s2_vld_d;
      if (cmd_i.load_n) begin
        n_q <= n_sat;
      end
      if (cmd_i.trk_clr) begin
        found_q <= 1'b0;
      end else if (scan_better) begin
        found_q <= 1'b1;
      end
    end
  end

  // Adjacency write port: clearing sweep or a write item
  always_comb begin
    adj_we    = 1'b0;
    adj_waddr = cnt_q;
    adj_wdata = NO_EDGE;
    if (cmd_i.op == OP_CLEAR) begin
      adj_we = 1'b1;
    end else if (cmd_i.adj_wr && in_range) begin
      adj_we    = 1'b1;
      adj_waddr = adj_addr(row_ext[VIDX_W-1:0], col_ext[VIDX_W-1:0]);
      adj_wdata = weight_i;
    end
  end

  // Adjacency read: row of the picked vertex, or a tree edge when summing
  assign adj_raddr = (s1_op_q == OP_SUM) ? adj_addr(s1_idx_q, work_rd_q.parent)
                                         : adj_addr(u_q, cidx);

  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    adj_rd_q <= adj_mem[adj_raddr];
  end

  // Minimum search, strict compare keeps the lowest index
  assign scan_better = (s1_op_q == OP_SCAN) && !work_rd_q.fin && (work_rd_q.key < min_q);

  // Working memory write: initial entries, or relaxation of the entry read last cycle
  always_comb begin
    work_we    = 1'b0;
    work_waddr = cidx;
    work_wdata = work_rd_q;
    if (cmd_i.op == OP_INIT) begin
      work_we               = 1'b1;
      work_wdata.has_parent = 1'b0;
      work_wdata.fin        = 1'b0;
      work_wdata.parent     = '0;
      work_wdata.key        = (cidx == '0) ? '0 : NO_EDGE;
    end else if (s1_op_q == OP_RELAX) begin
      work_waddr = s1_idx_q;
      if (s1_idx_q == u_q) begin
        work_we        = 1'b1;
        work_wdata.fin = 1'b1;
      end else if (!work_rd_q.fin && (adj_rd_q != NO_EDGE) && (work_rd_q.key > adj_rd_q)) begin
        work_we               = 1'b1;
        work_wdata.has_parent = 1'b1;
        work_wdata.parent     = u_q;
        work_wdata.key        = adj_rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (work_we) begin
      work_mem[work_waddr] <= work_wdata;
    end
    work_rd_q <= work_mem[cidx];
  end

  // Payload pipeline and tracker
  always_ff @(posedge clk_i) begin
    s1_idx_q <= cidx;
    if (cmd_i.trk_clr) begin
      u_q   <= '0;
      min_q <= NO_EDGE;
    end else if (scan_better) begin
      u_q   <= s1_idx_q;
      min_q <= work_rd_q.key;
    end
  end

  // Tree weight accumulation, saturating
  assign s2_vld_d = (s1_op_q == OP_SUM) && work_rd_q.has_parent;
  assign acc_sum  = {1'b0, acc_q} + (TW_W + 1)'(adj_rd_q);

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.acc_clr) begin
      acc_d = '0;
    end else if (s2_vld_q) begin
      acc_d = (acc_sum > {1'b0, SUM_MAX}) ? SUM_MAX : acc_sum[TW_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Status
  assign sts_o.clear_last = (cnt_q == ADDR_W'(ADJ_DEPTH - 1));
  assign sts_o.sweep_last = (cnt_q == ADDR_W'(n_q - VCNT_W'(1)));
  assign sts_o.cfg_zero   = (n_sat == '0);
  assign sts_o.found      = found_q;

  assign tree_weight_o = acc_q;

endmodule

// ----- hdl/prim_mst_weight.sv -----
// Top level of the minimum spanning tree weight block
//
//  channel   direction  transfer                      payload
//  item      in         start & !busy                 action_i, row_i, col_i, weight_i
//  result    out        done_o, one cycle             tree_weight_o
//  config    in         psel & penable & pwrite       paddr, pwdata (vertex_count at 0)
//
// A write item leaves busy low, so writes can follow every cycle.
// A clear item is taken, then busy stays high while every matrix entry is set to no-edge.
// A compute over n vertices runs an init pass, then a scan and a relax pass per vertex
//   reached, a last scan and a sum pass; each pass walks the single read port of each
//   memory once per vertex in use.
// After reset a clearing pass over every matrix entry runs with busy high; config
//   writes are taken throughout. Results cannot be stalled.
module prim_mst_weight (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // item channel
  input  logic                              start,
  output logic                              busy,
  input  logic [pmw_pkg::ACTION_W-1:0]      action_i,
  input  logic [pmw_pkg::ROW_W-1:0]         row_i,
  input  logic [pmw_pkg::COL_W-1:0]         col_i,
  input  logic [pmw_pkg::WEIGHT_W-1:0]      weight_i,
  // result channel
  output logic                              done_o,
  output logic [pmw_pkg::TW_W-1:0]          tree_weight_o,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pmw_pkg::APB_AW-1:0]        paddr,
  input  logic [pmw_pkg::APB_DW-1:0]        pwdata,
  output logic [pmw_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);
  import pmw_pkg::*;

  logic [VCOUNT_W-1:0] vertex_count_q;
  logic                cfg_sel;
  dp_cmd_t             cmd;
  dp_sts_t             sts;

  // Register decode: index 0 at byte address 0
  assign cfg_sel = (paddr[2] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? APB_DW'(vertex_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= VCOUNT_RESET;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      vertex_count_q <= pwdata[VCOUNT_W-1:0];
    end
  end

  pmw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .action_i (action_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  pmw_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .vertex_count_i (vertex_count_q),
    .row_i          (row_i),
    .col_i          (col_i),
    .weight_i       (weight_i),
    .tree_weight_o  (tree_weight_o)
  );

endmodule

// ----- hdl/pmw_checker.sv -----
// Port-level checker of the minimum spanning tree weight block, with its bind
`include "assert_macros.svh"

module pmw_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic [pmw_pkg::ACTION_W-1:0]      action_i,
  input logic                              done_o,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [pmw_pkg::APB_AW-1:0]        paddr,
  input logic [pmw_pkg::APB_DW-1:0]        pwdata,
  input logic [pmw_pkg::APB_DW-1:0]        prdata
);
  import pmw_pkg::*;

  // result strobe lasts a single cycle
  `ASSERT_BLK(a_done_pulse, done_o |=> !done_o, "result strobe longer than one cycle")

  // a result is shown only while the block is busy
  `ASSERT_BLK(a_done_busy, done_o |-> busy, "result strobe while idle")

  // clear and compute transfers hold the block busy
  `ASSERT_BLK(a_long_busy, (start && !busy && (action_i == ACT_CLEAR || action_i == ACT_COMPUTE)) |=> busy, "long item did not raise busy")

  // a write transfer produces no result
  `ASSERT_BLK(a_write_quiet, (start && !busy && action_i == ACT_WRITE) |=> !done_o, "result after a write item")

  // a register write reads back
  `ASSERT_BLK(a_cfg_readback, (psel && penable && pwrite && paddr[2] == 1'b0) |=> (prdata[VCOUNT_W-1:0] == $past(pwdata[VCOUNT_W-1:0])), "vertex count readback mismatch")

endmodule

bind prim_mst_weight pmw_checker u_checker (.*);

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the minimum spanning tree weight block
module tb;
  import pmw_pkg::*;

  localparam int unsigned             CYCLE_LIMIT = 3_000_000;
  localparam logic [ACTION_W-1:0]     ACT_UNUSED  = 2'd3;
  localparam logic [WEIGHT_W-1:0]     WEIGHT_TOP  = '1;
  localparam logic [APB_AW-1:0]       ADDR_VCOUNT = '0;

  typedef struct {
    logic [ACTION_W-1:0] action;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [WEIGHT_W-1:0] weight;
  } mat_op_t;

  // Block ports
  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                start    = 1'b0;
  logic [ACTION_W-1:0] action_i = '0;
  logic [ROW_W-1:0]    row_i    = '0;
  logic [COL_W-1:0]    col_i    = '0;
  logic [WEIGHT_W-1:0] weight_i = '0;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [APB_AW-1:0]   paddr    = '0;
  logic [APB_DW-1:0]   pwdata   = '0;
  logic                busy;
  logic                done_o;
  logic [TW_W-1:0]     tree_weight_o;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // Predictor state: matrix copy and configured vertex count
  logic [WEIGHT_W-1:0] adj_q [MAX_V][MAX_V];
  logic [VCOUNT_W-1:0] vcount_q;

  mat_op_t         pending_ops [$];
  logic [TW_W-1:0] weight_expect [$];
  mat_op_t         cur_op;
  logic [TW_W-1:0] exp_w;

  int unsigned ops_sent;
  int unsigned weights_checked;
  int unsigned saturated_cnt;
  int unsigned settings_cnt;
  int unsigned fail_cnt;
  int unsigned clears_left;
  int unsigned gap_left;
  int unsigned cyc_cnt;
  bit          no_gap_run;

  prim_mst_weight u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .weight_i      (weight_i),
    .done_o        (done_o),
    .tree_weight_o (tree_weight_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial forever #5 clk_i = ~clk_i;

  // Fill the matrix copy with no-edge
  function automatic void clear_matrix();
    for (int i = 0; i < MAX_V; i++) begin
      for (int j = 0; j < MAX_V; j++) begin
        adj_q[i][j] = NO_EDGE;
      end
    end
  endfunction

  // Prim walk from vertex 0; tree weight summed over the reverse entries
  function automatic logic [TW_W-1:0] mst_weight();
    int unsigned         n;
    int unsigned         u;
    logic [WEIGHT_W-1:0] minv;
    logic [WEIGHT_W-1:0] w;
    logic [WEIGHT_W-1:0] key [MAX_V];
    int unsigned         par [MAX_V];
    bit                  linked [MAX_V];
    bit                  taken [MAX_V];
    bit                  found;
    longint unsigned     total;
    n = (vcount_q > MAX_V) ? MAX_V : vcount_q;
    if (n == 0) return '0;
    for (int i = 0; i < n; i++) begin
      key[i]    = NO_EDGE;
      par[i]    = 0;
      linked[i] = 1'b0;
      taken[i]  = 1'b0;
    end
    key[0] = '0;
    found  = 1'b1;
    while (found) begin
      minv  = NO_EDGE;
      u     = 0;
      found = 1'b0;
      // lowest index wins a tie, since the compare is strict
      for (int i = 0; i < n; i++) begin
        if (!taken[i] && key[i] < minv) begin
          u     = i;
          minv  = key[i];
          found = 1'b1;
        end
      end
      if (found) begin
        taken[u] = 1'b1;
        for (int v = 0; v < n; v++) begin
          w = adj_q[u][v];
          if (!taken[v] && w != NO_EDGE && key[v] > w) begin
            key[v]    = w;
            par[v]    = u;
            linked[v] = 1'b1;
          end
        end
      end
    end
    total = 0;
    for (int i = 0; i < n; i++) begin
      if (linked[i]) total += adj_q[i][par[i]];
    end
    if (total > SUM_MAX) total = SUM_MAX;
    return TW_W'(total);
  endfunction

  // Update the predictor with one accepted item
  function automatic void apply_op(mat_op_t op);
    case (op.action)
      ACT_WRITE:   adj_q[op.row][op.col] = op.weight;
      ACT_CLEAR:   clear_matrix();
      ACT_COMPUTE: weight_expect.push_back(mst_weight());
      default: ;
    endcase
  endfunction

  // Gap before the next item, with occasional runs of back-to-back items
  function automatic int unsigned draw_gap();
    if ($urandom_range(0, 31) == 0) no_gap_run = !no_gap_run;
    return no_gap_run ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic void queue_op(logic [ACTION_W-1:0] a, logic [ROW_W-1:0] r,
                                   logic [COL_W-1:0] c, logic [WEIGHT_W-1:0] w);
    mat_op_t op;
    op.action = a;
    op.row    = r;
    op.col    = c;
    op.weight = w;
    pending_ops.push_back(op);
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return WEIGHT_W'($urandom_range(0, 7));
    if (r < 65) return WEIGHT_W'($urandom_range(0, 255));
    if (r < 80) return WEIGHT_W'($urandom_range(0, NO_EDGE));
    if (r < 88) return NO_EDGE;
    return WEIGHT_W'($urandom);
  endfunction

  // Mostly vertices in use, now and then anywhere in the matrix
  function automatic logic [ROW_W-1:0] pick_vertex(int unsigned n);
    if (n == 0 || $urandom_range(0, 9) == 0) return ROW_W'($urandom_range(0, MAX_V - 1));
    return ROW_W'($urandom_range(0, ((n > MAX_V) ? MAX_V : n) - 1));
  endfunction

  // Bursts of edge writes closed by a compute, with clears and noise between
  function automatic void random_phase(int unsigned n, int unsigned quota);
    int unsigned         cnt;
    int unsigned         r;
    logic [ROW_W-1:0]    a;
    logic [COL_W-1:0]    b;
    logic [WEIGHT_W-1:0] w;
    cnt = 0;
    while (cnt < quota) begin
      r = $urandom_range(0, 99);
      if (r < 3 && clears_left != 0) begin
        clears_left--;
        queue_op(ACT_CLEAR, ROW_W'($urandom), COL_W'($urandom), WEIGHT_W'($urandom));
        cnt++;
      end else if (r < 7) begin
        // ignored action, does not count
        queue_op(ACT_UNUSED, ROW_W'($urandom), COL_W'($urandom), WEIGHT_W'($urandom));
      end else if (r < 12) begin
        queue_op(ACT_WRITE, ROW_W'($urandom), COL_W'($urandom), WEIGHT_W'($urandom));
        cnt++;
      end else begin
        repeat ($urandom_range(1, 10)) begin
          a = pick_vertex(n);
          b = pick_vertex(n);
          w = rand_weight();
          queue_op(ACT_WRITE, a, b, w);
          cnt++;
          if ($urandom_range(0, 1) != 0) begin
            queue_op(ACT_WRITE, b, a, w);
            cnt++;
          end
        end
        queue_op(ACT_COMPUTE, ROW_W'($urandom), COL_W'($urandom), WEIGHT_W'($urandom));
        cnt++;
      end
    end
    queue_op(ACT_COMPUTE, '0, '0, '0);
  endfunction

  // Item driver: holds start until the transfer, then waits its drawn gap
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_op(cur_op);
        ops_sent++;
        gap_left = draw_gap();
      end
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          cur_op = pending_ops.pop_front();
          start    <= 1'b1;
          action_i <= cur_op.action;
          row_i    <= cur_op.row;
          col_i    <= cur_op.col;
          weight_i <= cur_op.weight;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (weight_expect.size() == 0) begin
        $error("tree_weight: got %0d with no result expected", tree_weight_o);
        fail_cnt++;
      end else begin
        exp_w = weight_expect.pop_front();
        weights_checked++;
        if (exp_w == SUM_MAX) saturated_cnt++;
        if (tree_weight_o !== exp_w) begin
          $error("tree_weight: expected %0d, actual %0d", exp_w, tree_weight_o);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Config write then read-back of vertex_count; upper data bits are don't-care
  task automatic set_vcount(logic [VCOUNT_W-1:0] val);
    logic [APB_DW-1:0] data;
    data                 = $urandom;
    data[VCOUNT_W-1:0]   = val;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_VCOUNT;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    vcount_q = val;
    settings_cnt++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[VCOUNT_W-1:0] !== val) begin
      $error("vertex_count: expected %0d, actual %0d", val, prdata[VCOUNT_W-1:0]);
      fail_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Wait until all items are sent, all results are in and the block is idle
  task automatic drain();
    do @(negedge clk_i);
    while (pending_ops.size() != 0 || start || weight_expect.size() != 0);
    repeat (4) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  // Stimulus sequence
  initial begin
    int unsigned n_sel;
    clear_matrix();
    vcount_q    = VCOUNT_RESET;
    clears_left = 3;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset count: one vertex, empty tree; unused action ignored
    queue_op(ACT_COMPUTE, '0, '0, '0);
    queue_op(ACT_UNUSED, '1, '1, WEIGHT_TOP);
    drain();
    // zero vertices in use
    set_vcount('0);
    queue_op(ACT_COMPUTE, '1, '1, WEIGHT_TOP);
    drain();
    // small graph: ties, asymmetric entries, explicit no-edge, weights above it
    set_vcount(VCOUNT_W'(4));
    queue_op(ACT_WRITE, 7'd0, 7'd1, 22'd5);
    queue_op(ACT_WRITE, 7'd1, 7'd0, 22'd7);
    queue_op(ACT_WRITE, 7'd0, 7'd2, 22'd5);
    queue_op(ACT_WRITE, 7'd2, 7'd0, WEIGHT_TOP);
    queue_op(ACT_WRITE, 7'd1, 7'd3, NO_EDGE);
    queue_op(ACT_WRITE, 7'd0, 7'd3, WEIGHT_TOP);
    queue_op(ACT_WRITE, '1, '1, '0);
    queue_op(ACT_WRITE, '0, '1, '0);
    queue_op(ACT_COMPUTE, '0, '0, '0);
    queue_op(ACT_WRITE, 7'd2, 7'd3, '0);
    queue_op(ACT_COMPUTE, '0, '0, '0);
    queue_op(ACT_CLEAR, '0, '0, '0);
    queue_op(ACT_COMPUTE, '0, '0, '0);
    drain();

    // random phases over small vertex counts, one at a single vertex, one at zero
    for (int p = 0; p < 12; p++) begin
      n_sel = (p == 3) ? 1 : (p == 7) ? 0 : $urandom_range(2, 16);
      set_vcount(VCOUNT_W'(n_sel));
      random_phase(n_sel, 130);
      drain();
    end

    // full size: a chain with heavy reverse entries drives the sum to saturation
    set_vcount(VCOUNT_W'(MAX_V));
    for (int v = 1; v < MAX_V; v++) begin
      queue_op(ACT_WRITE, ROW_W'(v - 1), COL_W'(v), WEIGHT_W'($urandom_range(0, 1000)));
      if ($urandom_range(0, 4) != 0)
        queue_op(ACT_WRITE, ROW_W'(v), COL_W'(v - 1),
                 WEIGHT_W'($urandom_range(NO_EDGE, WEIGHT_TOP)));
    end
    queue_op(ACT_COMPUTE, '0, '0, '0);
    drain();
    // count above the built maximum saturates
    set_vcount(VCOUNT_W'(200));
    queue_op(ACT_COMPUTE, '0, '0, '0);
    drain();
    // sparse full-size graph with unreachable vertices
    set_vcount('1);
    queue_op(ACT_CLEAR, '0, '0, '0);
    repeat (20) begin
      queue_op(ACT_WRITE, ROW_W'($urandom_range(0, 3)), ROW_W'($urandom), rand_weight());
    end
    queue_op(ACT_COMPUTE, '0, '0, '0);
    drain();
    repeat (100) @(negedge clk_i);

    $display("tb: %0d items sent over %0d vertex_count settings", ops_sent, settings_cnt);
    $display("tb: %0d tree weights checked, %0d of them saturated",
             weights_checked, saturated_cnt);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
